FILE: rtl/rab_pkg.sv
// shared types and constants for the running average background block
package rab_pkg;

  localparam int PIX_W   = 8;
  localparam int CNT_W   = 16;
  localparam int DIV_W   = CNT_W + 1;
  localparam int CFG_W_W = 11;
  localparam int CFG_H_W = 10;
  localparam int CFG_D_W = 11;
  localparam int CFG_I_W = 1;

  localparam logic [CNT_W-1:0]   CNT_MAX      = 16'hFFFF;
  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 10'd480;

  localparam logic [CFG_I_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_I_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic latch;
    logic div_start;
    logic rd_en;
    logic mul_en;
    logic commit;
  } rab_cmd_t;

  typedef struct packed {
    logic first_pix;
    logic div_done;
  } rab_sts_t;

endpackage

FILE: rtl/rab_in_if.sv
// pixel input channel
interface rab_in_if;
  logic                       valid;
  logic                       ready;
  logic [rab_pkg::PIX_W-1:0]  chan0;
  logic [rab_pkg::PIX_W-1:0]  chan1;
  logic [rab_pkg::PIX_W-1:0]  chan2;
  logic                       restart;

  modport source (output valid, chan0, chan1, chan2, restart, input ready);
  modport sink   (input valid, chan0, chan1, chan2, restart, output ready);
endinterface

FILE: rtl/rab_out_if.sv
// background result channel
interface rab_out_if;
  logic                       valid;
  logic                       ready;
  logic [rab_pkg::PIX_W-1:0]  bg_chan0;
  logic [rab_pkg::PIX_W-1:0]  bg_chan1;
  logic [rab_pkg::PIX_W-1:0]  bg_chan2;
  logic [rab_pkg::CNT_W-1:0]  frames_averaged;
  logic                       end_of_frame;

  modport source (output valid, bg_chan0, bg_chan1, bg_chan2, frames_averaged,
                  end_of_frame, input ready);
  modport sink   (input valid, bg_chan0, bg_chan1, bg_chan2, frames_averaged,
                  end_of_frame, output ready);
endinterface

FILE: rtl/running_average_background_top.sv
// Running average background model: pixel stream in, per-pixel background out.
// in_ch carries one raster-order pixel a beat (three 8-bit channels and restart);
// out_ch returns one beat per pixel: the updated background, the number of
// frames averaged so far and an end-of-frame flag on the last pixel.
// cfg_we/cfg_index/cfg_data write frame_width (index 0) and frame_height
// (index 1); write them only while no pixel is in flight.
// An ordinary pixel passes through the store read, one multiply per channel,
// then the blend and store write-back; the block takes the next pixel only
// once it is back in idle, not while one is in flight. The first pixel of a
// frame first runs the bit-serial weight divider, one quotient bit a cycle.
// Reset returns the dimensions to 640 x 480, the raster position to the top
// left and the frame count to zero; the store is not cleared, the first frame
// overwrites it. restart on a frame's first pixel starts the average afresh.
// The result sits in an output register until taken; meanwhile the next pixel
// is accepted and waits in its last stage for that register to free up.
module running_average_background_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rab_in_if.sink                      in_ch,
  rab_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [rab_pkg::CFG_I_W-1:0] cfg_index,
  input  logic [rab_pkg::CFG_D_W-1:0] cfg_data
);

  rab_pkg::rab_cmd_t cmd;
  rab_pkg::rab_sts_t sts;

  rab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rab_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_chan0            (in_ch.chan0),
    .in_chan1            (in_ch.chan1),
    .in_chan2            (in_ch.chan2),
    .in_restart          (in_ch.restart),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_bg_chan0        (out_ch.bg_chan0),
    .out_bg_chan1        (out_ch.bg_chan1),
    .out_bg_chan2        (out_ch.bg_chan2),
    .out_frames_averaged (out_ch.frames_averaged),
    .out_end_of_frame    (out_ch.end_of_frame)
  );

`ifndef SYNTHESIS
  // a result never overwrites one that has not been taken
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("result committed over a waiting beat");

  // no new pixel is taken while one is in the read, multiply or commit stage
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_en || cmd.commit || cmd.rd_en) |-> !in_ch.ready)
    else $error("input ready while a pixel is in flight");

  // a result cannot appear the cycle after its pixel is accepted
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !$rose(out_ch.valid))
    else $error("result too early after accept");
`endif

endmodule

FILE: rtl/rab_div.sv
// bit-serial restoring divider for the frame weight 2^FRAC_BITS / divisor
module rab_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rab_pkg::DIV_W-1:0] divisor,
  output logic [FRAC_BITS:0]        quotient,
  output logic                      done
);

  localparam int CW    = $clog2(FRAC_BITS + 1);
  localparam int REM_W = rab_pkg::DIV_W + 1;

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [FRAC_BITS:0] q_r;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;

  // the dividend has a single one, at its top bit
  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], (cnt_r == CW'(FRAC_BITS))};
    fits   = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(FRAC_BITS);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
      q_r   <= {q_r[FRAC_BITS-1:0], fits};
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

FILE: rtl/rab_ctrl.sv
// sequencer for one pixel at a time: weight, store read, multiply, commit
module rab_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rab_pkg::rab_sts_t sts,
  output rab_pkg::rab_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_READ,
    S_MUL,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = sts.first_pix ? S_DIV_GO : S_READ;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // wait here while the previous result still sits in the output register
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/rab_dp.sv
// datapath: raster position, frame count, weight, background store and blend lanes
module rab_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rab_pkg::CFG_I_W-1:0] cfg_index,
  input  logic [rab_pkg::CFG_D_W-1:0] cfg_data,
  input  logic [rab_pkg::PIX_W-1:0]   in_chan0,
  input  logic [rab_pkg::PIX_W-1:0]   in_chan1,
  input  logic [rab_pkg::PIX_W-1:0]   in_chan2,
  input  logic                        in_restart,
  input  rab_pkg::rab_cmd_t           cmd,
  output rab_pkg::rab_sts_t           sts,
  output logic [rab_pkg::PIX_W-1:0]   out_bg_chan0,
  output logic [rab_pkg::PIX_W-1:0]   out_bg_chan1,
  output logic [rab_pkg::PIX_W-1:0]   out_bg_chan2,
  output logic [rab_pkg::CNT_W-1:0]   out_frames_averaged,
  output logic                        out_end_of_frame
);

  localparam int PW     = rab_pkg::PIX_W;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIMW_W = $clog2(MAX_WIDTH + 1);
  localparam int DIMH_W = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int PROD_W = FRAC_BITS + 11;

  logic [rab_pkg::CFG_W_W-1:0] fw_r;
  logic [rab_pkg::CFG_H_W-1:0] fh_r;
  logic [COL_W-1:0]            col_r;
  logic [ROW_W-1:0]            row_r;
  logic [rab_pkg::CNT_W-1:0]   fc_r;
  logic [WT_W-1:0]             wt_r;
  logic [PW-1:0]               pix_r [3];
  logic [3*PW-1:0]             rd_r;
  logic signed [PROD_W-1:0]    prod_r [3];
  logic [3*PW-1:0]             mem [DEPTH];

  logic [DIMW_W-1:0]           wc;
  logic [DIMH_W-1:0]           hc;
  logic                        last_col;
  logic                        last_row;
  logic [ADDR_W-1:0]           addr;
  logic [rab_pkg::DIV_W-1:0]   divisor;
  logic [WT_W-1:0]             quotient;
  logic                        div_done;
  logic [PW-1:0]               bg [3];
  logic signed [PW:0]          diff [3];
  logic signed [PROD_W-1:0]    sh [3];
  logic [PW+1:0]               sum [3];
  logic [PW-1:0]               res [3];
  logic [rab_pkg::CNT_W-1:0]   shown;

  // dimensions: zero acts as one, anything past the maximum as the maximum
  always_comb begin
    if (fw_r == '0) wc = DIMW_W'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH)) wc = DIMW_W'(MAX_WIDTH);
    else wc = DIMW_W'(fw_r);
    if (fh_r == '0) hc = DIMH_W'(1);
    else if (32'(fh_r) > 32'(MAX_HEIGHT)) hc = DIMH_W'(MAX_HEIGHT);
    else hc = DIMH_W'(fh_r);
  end

  assign last_col = (32'(col_r) + 32'd1) >= 32'(wc);
  assign last_row = (32'(row_r) + 32'd1) >= 32'(hc);
  assign addr     = ADDR_W'(row_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_r);
  assign divisor  = {1'b0, fc_r} + rab_pkg::DIV_W'(1);
  assign shown    = (fc_r == rab_pkg::CNT_MAX) ? rab_pkg::CNT_MAX
                                               : fc_r + rab_pkg::CNT_W'(1);

  assign sts.first_pix = (col_r == '0) && (row_r == '0);
  assign sts.div_done  = div_done;

  rab_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // bg' = bg + floor((p - bg) * w / 2^FRAC_BITS), same as the two-term blend
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bg[k]   = rd_r[k*PW +: PW];
      diff[k] = $signed({1'b0, pix_r[k]}) - $signed({1'b0, bg[k]});
      sh[k]   = prod_r[k] >>> FRAC_BITS;
      sum[k]  = sh[k][PW+1:0] + {2'b00, bg[k]};
      res[k]  = sum[k][PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= rab_pkg::WIDTH_RESET;
      fh_r  <= rab_pkg::HEIGHT_RESET;
      col_r <= '0;
      row_r <= '0;
      fc_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rab_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_data[rab_pkg::CFG_W_W-1:0];
          rab_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_data[rab_pkg::CFG_H_W-1:0];
          default: ;
        endcase
      end
      if (cmd.latch && sts.first_pix && in_restart) fc_r <= '0;
      if (cmd.commit) begin
        if (last_col) begin
          col_r <= '0;
          if (last_row) begin
            row_r <= '0;
            if (fc_r != rab_pkg::CNT_MAX) fc_r <= fc_r + rab_pkg::CNT_W'(1);
          end else begin
            row_r <= row_r + ROW_W'(1);
          end
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pix_r[0] <= in_chan0;
      pix_r[1] <= in_chan1;
      pix_r[2] <= in_chan2;
    end
    if (div_done) wt_r <= quotient;
    if (cmd.mul_en) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'(diff[k]) * PROD_W'($signed({1'b0, wt_r}));
      end
    end
    if (cmd.commit) begin
      out_bg_chan0        <= res[0];
      out_bg_chan1        <= res[1];
      out_bg_chan2        <= res[2];
      out_frames_averaged <= shown;
      out_end_of_frame    <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_r <= mem[addr];
    if (cmd.commit) mem[addr] <= {res[2], res[1], res[0]};
  end

endmodule

FILE: tb/running_average_background_top_test.sv
// testbench for the running average background block: predicted beats against the pixel stream
`timescale 1ns / 100ps

module running_average_background_top_test;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 512;
  localparam int FRAC        = 16;
  localparam int ONE_W       = 1 << FRAC;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [rab_pkg::PIX_W-1:0] bg0;
    logic [rab_pkg::PIX_W-1:0] bg1;
    logic [rab_pkg::PIX_W-1:0] bg2;
    logic [rab_pkg::CNT_W-1:0] frames;
    logic                      eof;
  } bg_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [rab_pkg::CFG_I_W-1:0] cfg_index;
  logic [rab_pkg::CFG_D_W-1:0] cfg_data;

  rab_in_if  pix_if ();
  rab_out_if bg_if ();

  running_average_background_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_if),
    .out_ch   (bg_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted state of the block
  logic [rab_pkg::CNT_W-1:0]   frame_cnt;
  logic [9:0]                  col_pos;
  logic [8:0]                  row_pos;
  logic [rab_pkg::DIV_W-1:0]   weight;
  logic [rab_pkg::CFG_W_W-1:0] width_reg;
  logic [rab_pkg::CFG_H_W-1:0] height_reg;
  logic [23:0]                 bg_mem [int];

  bg_beat_t expected_bg_q [$];
  int       errors;
  int       quiet_cycles;
  bit       idle_on;

  function automatic int clamp_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [rab_pkg::PIX_W-1:0] mix_channel(
    logic [rab_pkg::PIX_W-1:0] old, logic [rab_pkg::PIX_W-1:0] pix,
    logic [rab_pkg::DIV_W-1:0] w);
    logic [31:0] acc;
    acc = 32'(old) * (32'(ONE_W) - 32'(w)) + 32'(pix) * 32'(w);
    return acc[FRAC+rab_pkg::PIX_W-1:FRAC];
  endfunction

  // true when every store entry from the current position to the end of the
  // frame, with the given dimensions, has been written since reset
  function automatic bit frame_rest_written(int w, int h);
    int r;
    int c;
    r = int'(row_pos);
    c = int'(col_pos);
    while (1) begin
      if (!bg_mem.exists(r * MAX_W + c)) return 1'b0;
      if (c + 1 >= w) begin
        if (r + 1 >= h) return 1'b1;
        c = 0;
        r = r + 1;
      end else begin
        c = c + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic bg_beat_t advance_background(
    logic [rab_pkg::PIX_W-1:0] c0, logic [rab_pkg::PIX_W-1:0] c1,
    logic [rab_pkg::PIX_W-1:0] c2, logic rs);
    bg_beat_t    beat;
    int          w_eff;
    int          h_eff;
    int          addr;
    logic [23:0] old;
    logic        last_col;
    logic        last_row;
    w_eff = clamp_dim(int'(width_reg), MAX_W);
    h_eff = clamp_dim(int'(height_reg), MAX_H);
    if (col_pos == '0 && row_pos == '0) begin
      if (rs) frame_cnt = '0;
      weight = rab_pkg::DIV_W'(32'(ONE_W) / (32'(frame_cnt) + 32'd1));
    end
    addr = int'(row_pos) * MAX_W + int'(col_pos);
    old = bg_mem.exists(addr) ? bg_mem[addr] : 24'd0;
    beat.bg0 = mix_channel(old[7:0], c0, weight);
    beat.bg1 = mix_channel(old[15:8], c1, weight);
    beat.bg2 = mix_channel(old[23:16], c2, weight);
    bg_mem[addr] = {beat.bg2, beat.bg1, beat.bg0};
    beat.frames = (frame_cnt != rab_pkg::CNT_MAX) ? frame_cnt + 16'd1 : rab_pkg::CNT_MAX;
    last_col = (int'(col_pos) + 1 >= w_eff);
    last_row = (int'(row_pos) + 1 >= h_eff);
    beat.eof = last_col && last_row;
    if (last_col) begin
      col_pos = '0;
      if (last_row) begin
        row_pos = '0;
        if (frame_cnt != rab_pkg::CNT_MAX) frame_cnt = frame_cnt + 16'd1;
      end else begin
        row_pos = row_pos + 9'd1;
      end
    end else begin
      col_pos = col_pos + 10'd1;
    end
    return beat;
  endfunction

  function automatic logic [rab_pkg::PIX_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rab_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel beat; called and left at a falling edge
  task automatic send_pixel(input logic [rab_pkg::PIX_W-1:0] c0,
                            input logic [rab_pkg::PIX_W-1:0] c1,
                            input logic [rab_pkg::PIX_W-1:0] c2, input logic rs_req);
    int   gap;
    logic rs;
    rs = rs_req;
    // a frame that would blend into unwritten entries starts afresh instead
    if (col_pos == '0 && row_pos == '0 && !rs && frame_cnt != '0 &&
        !frame_rest_written(clamp_dim(int'(width_reg), MAX_W),
                            clamp_dim(int'(height_reg), MAX_H)))
      rs = 1'b1;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid   <= 1'b1;
    pix_if.chan0   <= c0;
    pix_if.chan1   <= c1;
    pix_if.chan2   <= c2;
    pix_if.restart <= rs;
    do @(posedge clk); while (!pix_if.ready);
    expected_bg_q.push_back(advance_background(c0, c1, c2, rs));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    do @(negedge clk); while (expected_bg_q.size() != 0);
  endtask

  task automatic write_reg(input logic [rab_pkg::CFG_I_W-1:0] idx,
                           input logic [rab_pkg::CFG_D_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rab_pkg::REG_FRAME_WIDTH) width_reg = val[rab_pkg::CFG_W_W-1:0];
    else height_reg = val[rab_pkg::CFG_H_W-1:0];
    @(negedge clk);
  endtask

  // reset dimensions, restart away from the frame start, then a mid-frame shrink
  task automatic test_reset_state();
    idle_on = 1'b1;
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    wait_idle();
    write_reg(rab_pkg::REG_FRAME_WIDTH, 11'd2);
    write_reg(rab_pkg::REG_FRAME_HEIGHT, 11'd1);
    // column 3 lies past the new last column, so this beat closes the frame
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
  endtask

  task automatic test_blend_sequence();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd128, 8'd7, 8'd200, 1'b1);
    send_pixel(8'd64, 8'd1, 8'd254, 1'b0);
    send_pixel(8'd1, 8'd254, 8'd0, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    wait_idle();
    // grown frame over unwritten rows starts afresh
    write_reg(rab_pkg::REG_FRAME_HEIGHT, 11'd2);
    repeat (8) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
  endtask

  // zero dimensions, then a height past the maximum in a one-pixel-wide frame
  task automatic test_dimension_limits();
    wait_idle();
    write_reg(rab_pkg::REG_FRAME_WIDTH, 11'd0);
    write_reg(rab_pkg::REG_FRAME_HEIGHT, 11'd0);
    repeat (3) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
    wait_idle();
    write_reg(rab_pkg::REG_FRAME_WIDTH, 11'd1);
    write_reg(rab_pkg::REG_FRAME_HEIGHT, 11'h7FF);
    repeat (MAX_H) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
  endtask

  task automatic test_random_traffic();
    int                          sent;
    int                          n;
    int                          sel;
    logic [rab_pkg::CFG_D_W-1:0] nw;
    logic [rab_pkg::CFG_D_W-1:0] nh;
    sent = 0;
    while (sent < 400) begin
      idle_on = ($urandom_range(0, 3) != 0);
      wait_idle();
      sel = $urandom_range(0, 3);
      case ($urandom_range(0, 31))
        0:       nw = '0;
        1:       nw = rab_pkg::CFG_D_W'($urandom_range(9, 64));
        default: nw = rab_pkg::CFG_D_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 15))
        0:       nh = '0;
        1:       nh = rab_pkg::CFG_D_W'($urandom_range(5, 16));
        default: nh = rab_pkg::CFG_D_W'($urandom_range(1, 4));
      endcase
      if (sel == 1) nh = rab_pkg::CFG_D_W'(height_reg);
      if (sel == 2) nw = rab_pkg::CFG_D_W'(width_reg);
      // a mid-frame change must not send the rest of a blending frame over unwritten entries
      if (sel != 0 && !(col_pos == '0 && row_pos == '0) && frame_cnt != '0 &&
          !frame_rest_written(clamp_dim(int'(nw[rab_pkg::CFG_W_W-1:0]), MAX_W),
                              clamp_dim(int'(nh[rab_pkg::CFG_H_W-1:0]), MAX_H)))
        sel = 0;
      if (sel == 1 || sel == 3) write_reg(rab_pkg::REG_FRAME_WIDTH, nw);
      if (sel == 2 || sel == 3) write_reg(rab_pkg::REG_FRAME_HEIGHT, nh);
      n = $urandom_range(10, 80);
      repeat (n) send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 7) == 0);
      sent += n;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    pix_if.valid    = 1'b0;
    pix_if.chan0    = '0;
    pix_if.chan1    = '0;
    pix_if.chan2    = '0;
    pix_if.restart  = 1'b0;
    bg_if.ready     = 1'b0;
    frame_cnt       = '0;
    col_pos         = '0;
    row_pos         = '0;
    weight          = '0;
    width_reg       = rab_pkg::WIDTH_RESET;
    height_reg      = rab_pkg::HEIGHT_RESET;
    errors          = 0;
    idle_on         = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_blend_sequence();
    test_dimension_limits();
    test_random_traffic();
    wait_idle();
    repeat (40) @(negedge clk);
    if (expected_bg_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("[running_average_background_top] OK");
    end else begin
      $display("[running_average_background_top] ERROR");
    end
    $finish;
  end

  // result side: random stall before taking each beat while idle_on is set
  initial begin
    int stall;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        bg_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      bg_if.ready <= 1'b1;
      do @(posedge clk); while (!(bg_if.valid && bg_if.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    bg_beat_t got;
    bg_beat_t want;
    if (rst_n && bg_if.valid && bg_if.ready) begin
      got.bg0    = bg_if.bg_chan0;
      got.bg1    = bg_if.bg_chan1;
      got.bg2    = bg_if.bg_chan2;
      got.frames = bg_if.frames_averaged;
      got.eof    = bg_if.end_of_frame;
      if (expected_bg_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected beat: bg %0d %0d %0d frames %0d eof %0d",
                   got.bg0, got.bg1, got.bg2, got.frames, got.eof);
      end else begin
        want = expected_bg_q.pop_front();
        if (got.bg0 !== want.bg0 || got.bg1 !== want.bg1 || got.bg2 !== want.bg2 ||
            got.frames !== want.frames || got.eof !== want.eof) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("beat mismatch: exp bg %0d %0d %0d frames %0d eof %0d",
                     want.bg0, want.bg1, want.bg2, want.frames, want.eof);
            $display("               got bg %0d %0d %0d frames %0d eof %0d",
                     got.bg0, got.bg1, got.bg2, got.frames, got.eof);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (bg_if.valid && bg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[running_average_background_top] ERROR");
        $finish;
      end
    end
  end

endmodule
